// ===== hdl/gsem_pkg.sv =====
package gsem_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam int MIN_DIM = 3;

    localparam logic [15:0] GRAY_B = 16'd7471;
    localparam logic [15:0] GRAY_G = 16'd38470;
    localparam logic [15:0] GRAY_R = 16'd19595;

    localparam int SUM_W = 21;
    localparam logic [SUM_W-1:0] SQ_SAT = 21'd65025;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_green;
        logic [7:0] pixel_red;
    } t_pix_item;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       on_border;
        logic       frame_end;
    } t_edge_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_status;

    function automatic logic [7:0] gray_of(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
        logic [23:0] acc;
        acc = 24'(b) * 24'(GRAY_B) + 24'(g) * 24'(GRAY_G) + 24'(r) * 24'(GRAY_R);
        return acc[23:16];
    endfunction

endpackage

// ===== hdl/gsem_pix_if.sv =====
interface gsem_pix_if;
    import gsem_pkg::*;

    logic      valid;
    logic      ready;
    t_pix_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/gsem_edge_if.sv =====
interface gsem_edge_if;
    import gsem_pkg::*;

    logic       valid;
    logic       ready;
    t_edge_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/gsem_line_store.sv =====
module gsem_line_store #(
    parameter int DEPTH = gsem_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [15:0]              o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [15:0]              i_wr_data
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hdl/gsem_sqrt.sv =====
module gsem_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gsem_pkg::SUM_W-1:0]   i_sum,
    output gsem_pkg::t_sqrt_status       o_status,
    output logic [7:0]                   o_root
);
    import gsem_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [15:0] r_s;
    logic [7:0]  r_acc;
    logic [2:0]  r_bit;
    logic [7:0]  r_root;
    logic [7:0]  trial;
    logic [15:0] trial_sq;
    logic [7:0]  n_acc;

    always_comb begin
        trial    = r_acc | (8'd1 << r_bit);
        trial_sq = 16'(trial) * 16'(trial);
        n_acc    = (trial_sq < r_s) ? trial : r_acc;
    end

    // The loop finds the largest root whose square stays below the sum; one more is the ceiling.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_sum > SQ_SAT) begin
                    r_done <= 1'b1;
                    r_root <= 8'd255;
                end else begin
                    r_busy <= 1'b1;
                    r_s    <= i_sum[15:0];
                    r_acc  <= 8'd0;
                    r_bit  <= 3'd7;
                end
            end else if (r_busy) begin
                r_acc <= n_acc;
                if (r_bit == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_root <= (r_s == 16'd0) ? 8'd0 : n_acc + 8'd1;
                end else begin
                    r_bit <= r_bit - 3'd1;
                end
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_root        = r_root;
endmodule

// ===== hdl/grayscale_sobel_edge_magnitude_core.sv =====
// Raster-order BGR pixels enter, are converted to gray and shifted through a 3x3 window fed by
// a two-row line store; each interior pixel leaves as its saturated Sobel gradient magnitude
// and each border pixel as its gray value, one image width plus one item after it entered.
// Items are handled one at a time. Each pixel passes through a read-modify-write of the line
// store; an interior result then also waits on the square-root unit, which resolves one bit
// of the root per cycle unless the sum saturates. A result also waits while the previous one
// still sits unaccepted in the output register. Drain items flush the pending results after
// the last pixel. No clearing pass follows reset.
module grayscale_sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH  = gsem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gsem_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gsem_pix_if.sink                        i_pix,
    gsem_edge_if.source                     o_edge,
    input  logic                            i_cfg_we,
    input  logic [gsem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gsem_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gsem_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW0 = $clog2(MAX_WIDTH + 1);
    localparam int HW0 = $clog2(MAX_HEIGHT + 1);
    localparam int WW  = (CFG_WIDTH_W > WW0) ? CFG_WIDTH_W : WW0;
    localparam int HW  = (CFG_HEIGHT_W > HW0) ? CFG_HEIGHT_W : HW0;
    localparam int BW  = $clog2(MAX_WIDTH + 2);
    localparam int KW  = (BW > WW) ? BW : WW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROC,
        S_CALC,
        S_SQRT,
        S_OUT
    } t_state;

    t_state                  r_state, n_state;
    logic [CFG_WIDTH_W-1:0]  r_cfg_width, n_cfg_width;
    logic [CFG_HEIGHT_W-1:0] r_cfg_height, n_cfg_height;
    t_pix_item               r_item, n_item;
    logic [7:0]              r_win [3][3];
    logic [7:0]              n_win [3][3];
    logic [CW-1:0]           r_in_col, n_in_col;
    logic [RW-1:0]           r_in_row, n_in_row;
    logic [CW-1:0]           r_out_col, n_out_col;
    logic [RW-1:0]           r_out_row, n_out_row;
    logic [BW-1:0]           r_backlog, n_backlog;
    logic [7:0]              r_val, n_val;
    logic                    r_border, n_border;
    logic                    r_fend, n_fend;
    logic                    r_ov, n_ov;
    t_edge_item              r_opay, n_opay;

    logic [WW-1:0]    w_ext, w_eff;
    logic [HW-1:0]    h_ext, h_eff;
    logic [CW-1:0]    in_col_adv, out_col_adv;
    logic [RW-1:0]    in_row_adv, out_row_adv;
    logic [7:0]       gray;
    logic [15:0]      rd_data;
    logic             mem_we;
    logic             accept;
    logic             emit;
    logic             border_now;
    logic             fend_now;
    logic signed [10:0] gx, gy;
    logic signed [21:0] gx_sq, gy_sq;
    logic [SUM_W-1:0] sum;
    logic             sqrt_start;
    t_sqrt_status     sqrt_stat;
    logic [7:0]       sqrt_root;

    assign accept = i_pix.valid && i_pix.ready;
    assign gray = (r_item.opcode == OP_DRAIN) ? 8'd0 :
                  gray_of(r_item.pixel_blue, r_item.pixel_green, r_item.pixel_red);

    always_comb begin
        w_ext = WW'(r_cfg_width);
        h_ext = HW'(r_cfg_height);
        w_eff = (w_ext < WW'(MIN_DIM)) ? WW'(MIN_DIM) :
                ((w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext);
        h_eff = (h_ext < HW'(MIN_DIM)) ? HW'(MIN_DIM) :
                ((h_ext > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_ext);
    end

    always_comb begin
        if (WW'(r_in_col) + WW'(1) >= w_eff) begin
            in_col_adv = '0;
            in_row_adv = (HW'(r_in_row) + HW'(1) >= h_eff) ? '0 : r_in_row + RW'(1);
        end else begin
            in_col_adv = r_in_col + CW'(1);
            in_row_adv = r_in_row;
        end
        if (WW'(r_out_col) + WW'(1) >= w_eff) begin
            out_col_adv = '0;
            out_row_adv = (HW'(r_out_row) + HW'(1) >= h_eff) ? '0 : r_out_row + RW'(1);
        end else begin
            out_col_adv = r_out_col + CW'(1);
            out_row_adv = r_out_row;
        end
    end

    always_comb begin
        border_now = (r_out_row == '0) || (r_out_col == '0) ||
                     (HW'(r_out_row) >= h_eff - HW'(1)) || (WW'(r_out_col) >= w_eff - WW'(1));
        fend_now   = (HW'(r_out_row) == h_eff - HW'(1)) && (WW'(r_out_col) == w_eff - WW'(1));
    end

    always_comb begin
        gx = (11'(r_win[0][2]) + (11'(r_win[1][2]) << 1) + 11'(r_win[2][2])) -
             (11'(r_win[0][0]) + (11'(r_win[1][0]) << 1) + 11'(r_win[2][0]));
        gy = (11'(r_win[2][0]) + (11'(r_win[2][1]) << 1) + 11'(r_win[2][2])) -
             (11'(r_win[0][0]) + (11'(r_win[0][1]) << 1) + 11'(r_win[0][2]));
        gx_sq = gx * gx;
        gy_sq = gy * gy;
        sum   = gx_sq[SUM_W-1:0] + gy_sq[SUM_W-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_cfg_width  = r_cfg_width;
        n_cfg_height = r_cfg_height;
        n_item       = r_item;
        n_win        = r_win;
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_backlog    = r_backlog;
        n_val        = r_val;
        n_border     = r_border;
        n_fend       = r_fend;
        n_ov         = r_ov && !o_edge.ready;
        n_opay       = r_opay;
        mem_we       = 1'b0;
        emit         = 1'b0;
        sqrt_start   = 1'b0;

        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  n_cfg_width  = i_cfg_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: n_cfg_height = i_cfg_data[CFG_HEIGHT_W-1:0];
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item  = i_pix.payload;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                if (r_item.opcode == OP_DRAIN && r_backlog == '0) begin
                    n_state = S_IDLE;
                end else begin
                    mem_we = 1'b1;
                    for (int r = 0; r < 3; r++) begin
                        n_win[r][0] = r_win[r][1];
                        n_win[r][1] = r_win[r][2];
                    end
                    n_win[0][2] = rd_data[15:8];
                    n_win[1][2] = rd_data[7:0];
                    n_win[2][2] = gray;
                    n_in_col = in_col_adv;
                    n_in_row = in_row_adv;
                    if (r_item.opcode == OP_DRAIN) begin
                        emit      = 1'b1;
                        n_backlog = r_backlog - BW'(1);
                    end else if (KW'(r_backlog) > KW'(w_eff)) begin
                        emit = 1'b1;
                    end else begin
                        n_backlog = r_backlog + BW'(1);
                    end
                    if (emit) begin
                        n_border  = border_now;
                        n_fend    = fend_now;
                        n_val     = r_win[1][2];
                        n_out_col = out_col_adv;
                        n_out_row = out_row_adv;
                        n_state   = border_now ? S_OUT : S_CALC;
                    end else begin
                        n_state = S_IDLE;
                    end
                    if (r_item.opcode == OP_DRAIN && n_backlog == '0) begin
                        n_in_col  = '0;
                        n_in_row  = '0;
                        n_out_col = '0;
                        n_out_row = '0;
                    end
                end
            end
            S_CALC: begin
                sqrt_start = 1'b1;
                n_state    = S_SQRT;
            end
            S_SQRT: begin
                if (sqrt_stat.done) begin
                    n_val   = sqrt_root;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || o_edge.ready) begin
                    n_ov              = 1'b1;
                    n_opay.edge_value = r_val;
                    n_opay.on_border  = r_border;
                    n_opay.frame_end  = r_fend;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_backlog    <= '0;
            r_ov         <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= 8'd0;
                end
            end
        end else begin
            r_state      <= n_state;
            r_cfg_width  <= n_cfg_width;
            r_cfg_height <= n_cfg_height;
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_backlog    <= n_backlog;
            r_ov         <= n_ov;
            r_win        <= n_win;
        end
        r_item   <= n_item;
        r_val    <= n_val;
        r_border <= n_border;
        r_fend   <= n_fend;
        r_opay   <= n_opay;
    end

    assign i_pix.ready    = (r_state == S_IDLE);
    assign o_edge.valid   = r_ov;
    assign o_edge.payload = r_opay;

    gsem_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_in_col),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_in_col),
        .i_wr_data ({rd_data[7:0], gray})
    );

    gsem_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sqrt_start),
        .i_sum    (sum),
        .o_status (sqrt_stat),
        .o_root   (sqrt_root)
    );

    a_backlog_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KW'(r_backlog) <= KW'(MAX_WIDTH + 1))
        else $error("Backlog exceeds the window depth.");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < WW'(MAX_WIDTH))
        else $error("Line store address out of range.");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && (!r_ov || o_edge.ready) |=> r_ov)
        else $error("Result was not loaded into the output register.");

    a_sqrt_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> !sqrt_stat.busy)
        else $error("Square-root unit started while busy.");

    a_sqrt_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_stat.done |-> (r_state == S_SQRT))
        else $error("Square-root result arrived outside its wait state.");
endmodule

// ===== dv/grayscale_sobel_edge_magnitude_core_tb.sv =====
module grayscale_sobel_edge_magnitude_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsem_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int HEIGHT_CAP    = 4096;
    localparam int MIN_SIDE      = 3;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 650;

    localparam logic [23:0] WHITE      = 24'hFFFFFF;
    localparam logic [23:0] BLACK      = 24'h000000;
    localparam logic [23:0] BLUE_ONLY  = 24'hFF0000;
    localparam logic [23:0] GREEN_ONLY = 24'h00FF00;
    localparam logic [23:0] RED_ONLY   = 24'h0000FF;
    localparam logic [23:0] MUDDY      = 24'h0A141E;

    typedef enum int {
        TEX_NOISE,
        TEX_SMOOTH,
        TEX_STARK
    } t_texture;

    typedef struct {
        t_opcode     op;
        logic [23:0] bgr;
        bit          pinned;
        t_edge_item  want;
    } t_directed_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_reg i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gsem_pix_if  pix_if ();
    gsem_edge_if edge_if ();

    grayscale_sobel_edge_magnitude_core #(
        .MAX_WIDTH  (LINE_DEPTH),
        .MAX_HEIGHT (HEIGHT_CAP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_if),
        .o_edge      (edge_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // A 3x3 frame, then a second 3x3 frame back to back, then a flush.
    t_directed_row dir_rows [24] = '{
        '{OP_DRAIN, BLACK,      1'b0, 10'h000},
        '{OP_PIXEL, WHITE,      1'b0, 10'h000},
        '{OP_PIXEL, BLUE_ONLY,  1'b0, 10'h000},
        '{OP_PIXEL, GREEN_ONLY, 1'b0, 10'h000},
        '{OP_PIXEL, RED_ONLY,   1'b0, 10'h000},
        '{OP_PIXEL, MUDDY,      1'b1, {8'd255, 2'b10}},
        '{OP_PIXEL, WHITE,      1'b1, {8'd29,  2'b10}},
        '{OP_PIXEL, BLACK,      1'b1, {8'd149, 2'b10}},
        '{OP_PIXEL, WHITE,      1'b1, {8'd76,  2'b10}},
        '{OP_PIXEL, BLACK,      1'b0, 10'h000},
        '{OP_PIXEL, WHITE,      1'b1, {8'd255, 2'b10}},
        '{OP_PIXEL, BLACK,      1'b1, {8'd0,   2'b10}},
        '{OP_PIXEL, BLACK,      1'b1, {8'd255, 2'b10}},
        '{OP_PIXEL, WHITE,      1'b1, {8'd0,   2'b11}},
        '{OP_PIXEL, BLACK,      1'b1, {8'd255, 2'b10}},
        '{OP_PIXEL, BLACK,      1'b1, {8'd0,   2'b10}},
        '{OP_PIXEL, WHITE,      1'b1, {8'd0,   2'b10}},
        '{OP_PIXEL, BLACK,      1'b1, {8'd255, 2'b10}},
        '{OP_PIXEL, BLACK,      1'b1, {8'd255, 2'b00}},
        '{OP_DRAIN, BLACK,      1'b1, {8'd0,   2'b10}},
        '{OP_DRAIN, BLACK,      1'b1, {8'd255, 2'b10}},
        '{OP_DRAIN, BLACK,      1'b1, {8'd0,   2'b10}},
        '{OP_DRAIN, BLACK,      1'b1, {8'd0,   2'b11}},
        '{OP_DRAIN, BLACK,      1'b0, 10'h000}
    };

    logic [10:0] reg_width;
    logic [12:0] reg_height;
    logic [7:0]  row_above  [LINE_DEPTH];
    logic [7:0]  row_above2 [LINE_DEPTH];
    logic [7:0]  win [3][3];
    int unsigned in_col, in_row, out_col, out_row, backlog_cnt;

    t_edge_item edge_results_due [$];

    int unsigned burst_left;
    int unsigned items_taken, drains_taken, configs_done;
    int unsigned results_checked, mismatches;
    int unsigned quiet_cycles;
    logic [9:0]  rx_tick;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < MIN_SIDE) return MIN_SIDE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void advance_pos(inout int unsigned col, inout int unsigned row,
                                        input int unsigned w, input int unsigned h);
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
    endfunction

    function automatic logic [7:0] gray_level(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int unsigned acc;
        acc = 7471 * int'(b) + 38470 * int'(g) + 19595 * int'(r);
        return acc[23:16];
    endfunction

    function automatic logic [7:0] magnitude(int gx, int gy);
        int unsigned s, lo, hi, mid;
        s = gx * gx + gy * gy;
        if (s > 65025) return 8'd255;
        lo = 0;
        hi = 255;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (mid * mid >= s) hi = mid;
            else lo = mid + 1;
        end
        return lo[7:0];
    endfunction

    function automatic void shift_column(logic [7:0] g);
        int unsigned x;
        logic [7:0] up1, up2;
        x = in_col % LINE_DEPTH;
        up1 = row_above[x];
        up2 = row_above2[x];
        row_above2[x] = up1;
        row_above[x] = g;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = g;
    endfunction

    function automatic t_edge_item next_output(int unsigned w, int unsigned h);
        t_edge_item res;
        bit border;
        int gx, gy;
        border = out_row == 0 || out_col == 0 || out_row >= h - 1 || out_col >= w - 1;
        if (border) begin
            res.edge_value = win[1][1];
        end else begin
            gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
            gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
            res.edge_value = magnitude(gx, gy);
        end
        res.on_border = border;
        res.frame_end = out_row == h - 1 && out_col == w - 1;
        advance_pos(out_col, out_row, w, h);
        return res;
    endfunction

    function automatic bit track_item(t_pix_item it, output t_edge_item res);
        int unsigned w, h;
        w = clamp_dim(reg_width, LINE_DEPTH);
        h = clamp_dim(reg_height, HEIGHT_CAP);
        res = '0;
        if (it.opcode == OP_PIXEL) begin
            shift_column(gray_level(it.pixel_blue, it.pixel_green, it.pixel_red));
            advance_pos(in_col, in_row, w, h);
            backlog_cnt++;
            if (backlog_cnt > w + 1) begin
                res = next_output(w, h);
                backlog_cnt--;
                return 1'b1;
            end
            return 1'b0;
        end
        if (backlog_cnt == 0) return 1'b0;
        shift_column(8'd0);
        advance_pos(in_col, in_row, w, h);
        res = next_output(w, h);
        backlog_cnt--;
        if (backlog_cnt == 0) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] channel_value(t_texture tex, int base);
        int v;
        case (tex)
            TEX_NOISE: begin
                return 8'($urandom_range(0, 255));
            end
            TEX_SMOOTH: begin
                v = base + int'($urandom_range(0, 24)) - 12;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return 8'(v);
            end
            default: begin
                return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
        endcase
    endfunction

    function automatic t_pix_item random_pixel(t_texture tex, int base);
        t_pix_item it;
        it.opcode = OP_PIXEL;
        it.pixel_blue = channel_value(tex, base);
        it.pixel_green = channel_value(tex, base);
        it.pixel_red = channel_value(tex, base);
        return it;
    endfunction

    function automatic t_pix_item random_drain();
        t_pix_item it;
        it.opcode = OP_DRAIN;
        it.pixel_blue = 8'($urandom_range(0, 255));
        it.pixel_green = 8'($urandom_range(0, 255));
        it.pixel_red = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic void compare_edge_result(t_edge_item got);
        t_edge_item want;
        if (edge_results_due.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing outstanding: value %0d border %0b end %0b",
                     $time, got.edge_value, got.on_border, got.frame_end);
            return;
        end
        want = edge_results_due.pop_front();
        results_checked++;
        if (got.edge_value !== want.edge_value) begin
            mismatches++;
            $display("%0t: edge_value expected %0d, got %0d",
                     $time, want.edge_value, got.edge_value);
        end
        if (got.on_border !== want.on_border) begin
            mismatches++;
            $display("%0t: on_border expected %0b, got %0b",
                     $time, want.on_border, got.on_border);
        end
        if (got.frame_end !== want.frame_end) begin
            mismatches++;
            $display("%0t: frame_end expected %0b, got %0b",
                     $time, want.frame_end, got.frame_end);
        end
    endfunction

    task automatic deliver(input t_pix_item it, input bit pinned, input t_edge_item want,
                           output bit made);
        t_edge_item res;
        if (burst_left == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        pix_if.valid <= 1'b1;
        pix_if.payload <= it;
        do @(posedge i_clk); while (!pix_if.ready);
        made = track_item(it, res);
        if (made) edge_results_due.push_back(pinned ? want : res);
        items_taken++;
        if (it.opcode == OP_DRAIN) drains_taken++;
    endtask

    task automatic settle();
        pix_if.valid <= 1'b0;
        while (edge_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dims(logic [10:0] w_raw, logic [12:0] h_raw);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data <= 13'(w_raw);
        @(posedge i_clk);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data <= h_raw;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_width = w_raw;
        reg_height = h_raw;
        configs_done++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver steps through four ready patterns, chosen by the top two bits of a free-running tick.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            edge_if.ready <= 1'b0;
            rx_tick <= '0;
        end else begin
            if (edge_if.valid && edge_if.ready) compare_edge_result(edge_if.payload);
            rx_tick <= rx_tick + 10'd1;
            case (rx_tick[9:8])
                2'd0: edge_if.ready <= 1'b1;
                2'd1: edge_if.ready <= 1'($urandom_range(0, 1));
                2'd2: edge_if.ready <= rx_tick[3:0] >= 4'd10;
                default: edge_if.ready <= $urandom_range(0, 7) != 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pix_if.valid && pix_if.ready) || (edge_if.valid && edge_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_pix_item   it;
        t_edge_item  none;
        bit          made;
        logic [10:0] w_raw;
        logic [12:0] h_raw;
        int unsigned w_eff, h_eff, n_pix, random_items;
        t_texture    tex;
        int          base;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_IMAGE_WIDTH;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.payload = '0;
        edge_if.ready = 1'b0;
        quiet_cycles = 0;
        none = '0;
        random_items = 0;
        reg_width = 11'd640;
        reg_height = 13'd480;
        foreach (row_above[x]) begin
            row_above[x] = '0;
            row_above2[x] = '0;
        end
        foreach (win[r, c]) win[r][c] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        backlog_cnt = 0;
        burst_left = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_dims(11'd3, 13'd3);
        foreach (dir_rows[k]) begin
            it.opcode = dir_rows[k].op;
            {it.pixel_blue, it.pixel_green, it.pixel_red} = dir_rows[k].bgr;
            deliver(it, dir_rows[k].pinned, dir_rows[k].want, made);
        end

        while (random_items < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 9))
                0: w_raw = 11'($urandom_range(0, 2));
                1: w_raw = 11'd3;
                2: w_raw = 11'd2047;
                3: w_raw = 11'd1024;
                4: w_raw = 11'($urandom_range(1025, 2046));
                default: w_raw = 11'($urandom_range(4, 8));
            endcase
            case ($urandom_range(0, 7))
                0: h_raw = 13'($urandom_range(0, 2));
                1: h_raw = 13'd3;
                2: h_raw = 13'd8191;
                3: h_raw = 13'd4096;
                4: h_raw = 13'($urandom_range(4097, 8190));
                default: h_raw = 13'($urandom_range(4, 7));
            endcase
            write_dims(w_raw, h_raw);
            w_eff = clamp_dim(w_raw, LINE_DEPTH);
            h_eff = clamp_dim(h_raw, HEIGHT_CAP);
            tex = t_texture'($urandom_range(0, 2));
            base = $urandom_range(0, 255);
            if (w_eff > 16) n_pix = $urandom_range(5, 40);
            else if (h_eff > 8) n_pix = w_eff * $urandom_range(3, 8) + $urandom_range(0, w_eff);
            else n_pix = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff);

            repeat (n_pix) begin
                if ($urandom_range(0, 29) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        deliver(random_drain(), 1'b0, none, made);
                        if (made) random_items++;
                    end
                end
                deliver(random_pixel(tex, base), 1'b0, none, made);
                random_items++;
            end
            while (backlog_cnt != 0) begin
                deliver(random_drain(), 1'b0, none, made);
                random_items++;
            end
            repeat ($urandom_range(0, 2)) deliver(random_drain(), 1'b0, none, made);
        end

        settle();
        $display("Ran %0d transactions (%0d drains) over %0d register settings,",
                 items_taken, drains_taken, configs_done);
        $display("from 3x3 frames up to clamped extremes; %0d results compared, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && edge_results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
